// ----- design/assert_macros.svh -----
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define WTS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("wts check failed");

// Checked at every edge, reset included.
`define WTS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("wts check failed");

`endif

// ----- design/wts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package wts_pkg;
  localparam int WTS_MAX_SAMPLES = 1024;
  localparam int WTS_SCORE_BITS  = 16;
  localparam int FACE_VALUE      = 16384;
  localparam int WEIGHT_W        = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int SQ_W            = 42;
  localparam int COST_OUT_W      = 27;
  localparam int MSE_W           = 18;
  localparam int CPS_W           = 25;
  localparam logic [CFG_IDX_W-1:0] CFG_FP_WEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FN_WEIGHT = 2'd1;

  typedef enum logic [3:0] {
    S_LOAD, S_INIT, S_BEST, S_SWEEP, S_MSE_GO, S_MSE_WAIT,
    S_CPS_GO, S_CPS_WAIT, S_OUT
  } state_e;

  // Command shared by every cell of the sorting row.
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;
endpackage
`default_nettype wire

// ----- design/weighted_threshold_selector_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Weighted threshold selector. Pulse start with a (score, target, last) beat while busy is
// low; loading accepts one beat per cycle and the block stays ready throughout a set. The beat
// marked last raises busy while the set is evaluated: the block sets up and sweeps the
// sorting row, then makes two passes (42 quotient steps each) through a shared radix-2
// divider, one for the mean squared error and one for the cost per sample, and then
// presents the result. The result appears for exactly one cycle with done_o high and cannot
// be stalled, so the receiver must capture it in that cycle. Beyond MAX_SAMPLES, beats are dropped.
module weighted_threshold_selector_top import wts_pkg::*; #(
  parameter int MAX_SAMPLES = WTS_MAX_SAMPLES,
  parameter int SCORE_BITS  = WTS_SCORE_BITS,
  localparam int CW = $clog2(MAX_SAMPLES + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [SCORE_BITS-1:0] score_i,
  input  wire logic [SCORE_BITS-1:0] target_i,
  input  wire logic                  last_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [WEIGHT_W-1:0]   cfg_data_i,
  output logic                       done_o,
  output logic [SCORE_BITS-1:0]      best_threshold_o,
  output logic [CW-1:0]              false_pos_count_o,
  output logic [CW-1:0]              false_neg_count_o,
  output logic [COST_OUT_W-1:0]      best_cost_o,
  output logic [MSE_W-1:0]           mean_sq_error_o,
  output logic [CPS_W-1:0]           cost_per_sample_o,
  output logic [CW-1:0]              face_count_o,
  output logic [CW-1:0]              sample_count_o
);
  localparam int SW    = SCORE_BITS;
  localparam int COSTW = WEIGHT_W + CW + 1;
  localparam int DW    = (COSTW + 8 > SQ_W) ? COSTW + 8 : SQ_W;
  localparam logic [SQ_W-1:0] SQ_MAX = '1;

  state_e state_q, state_d;
  logic [WEIGHT_W-1:0] fpw_q, fnw_q;
  logic [CW-1:0] cnt_q, faces_q, occ_q, idx_q;
  logic [SQ_W-1:0] sum_q;
  logic accept, store;
  logic face_in;

  // Squared-error pipeline: magnitude now, square and accumulate next cycle.
  logic [SW:0]   diff;
  logic [SW:0]   ad;
  logic [32:0]   ad_ext;
  logic [20:0]   ad_q;
  logic          sat_q, sqv_q;
  logic [SQ_W-1:0] sq;

  assign accept  = start && !busy;
  assign store   = accept && (32'(cnt_q) < 32'(MAX_SAMPLES));
  assign face_in = 32'($signed(target_i)) == 32'(FACE_VALUE);
  assign diff    = (SW+1)'($signed(score_i)) - (SW+1)'($signed(target_i));
  assign ad      = diff[SW] ? (SW+1)'(-diff) : diff;
  assign ad_ext  = 33'(ad);
  assign sq      = SQ_W'(ad_q) * SQ_W'(ad_q);

  // Sorting row. Each beat is inserted after all stored scores not above it, which keeps
  // ties in arrival order; during the sweep the row shifts toward cell 0 once per cycle.
  cell_ctrl_t ctrl;
  logic [SW:0] key;
  logic [SW:0] cell_data [MAX_SAMPLES];
  logic        cell_keep [MAX_SAMPLES];

  assign key = {face_in, score_i};

  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_row
    logic [SW:0] left_d, right_d;
    logic        left_k;
    if (i == 0) begin : g_first
      assign left_d = key;
      assign left_k = 1'b1;
    end else begin : g_mid
      assign left_d = cell_data[i-1];
      assign left_k = cell_keep[i-1];
    end
    if (i == MAX_SAMPLES - 1) begin : g_end
      assign right_d = key;
    end else begin : g_inner
      assign right_d = cell_data[i+1];
    end
    wts_cell #(.SW(SW), .CW(CW), .IDX(i)) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occ_i       (occ_q),
      .key_i       (key),
      .left_data_i (left_d),
      .left_keep_i (left_k),
      .right_data_i(right_d),
      .data_o      (cell_data[i]),
      .keep_o      (cell_keep[i])
    );
  end

  // Sweep pipeline: pop and count, multiply, then add and compare.
  logic pop;
  logic [CW-1:0] fp_q, fn_q;
  logic signed [SW-1:0] prev_q;
  logic p1_q, p2_q;
  logic [CW-1:0] fp1_q, fn1_q, fp2_q, fn2_q;
  logic signed [SW-1:0] s1_q, pr1_q, s2_q, pr2_q;
  logic [COSTW-2:0] m1_q, m2_q;
  logic [COSTW-1:0] cost, best_q;
  logic [SW:0] mid;
  logic signed [SW-1:0] thr_q;
  logic [CW-1:0] bfp_q, bfn_q;

  assign pop  = (state_q == S_SWEEP) && (idx_q != cnt_q);
  assign cost = COSTW'(m1_q) + COSTW'(m2_q);
  assign mid  = ((SW+1)'(s2_q) + (SW+1)'(pr2_q)) >>> 1;

  always_comb begin
    ctrl.insert = store;
    ctrl.shift  = pop;
  end

  // Shared divider for the mean squared error and the cost per sample.
  logic div_start, div_done;
  logic [DW-1:0] div_dvd, quot;
  logic [CW-1:0] divisor;
  logic [MSE_W-1:0] mse_q;
  logic [CPS_W-1:0] cps_q;
  logic [DW-14-1:0] mse_raw;

  assign divisor = (cnt_q == '0) ? CW'(1) : cnt_q;
  assign div_dvd = (state_q == S_MSE_GO) ? DW'(sum_q) : (DW'(best_q) << 8);
  assign mse_raw = quot[DW-1:14];

  wts_div #(.DW(DW), .VW(CW)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dvd),
    .divisor_i (divisor),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    unique case (state_q)
      S_LOAD:     if (accept && last_i) state_d = S_INIT;
      S_INIT:     state_d = S_BEST;
      S_BEST:     state_d = S_SWEEP;
      S_SWEEP:    if (!pop && !p1_q && !p2_q) state_d = S_MSE_GO;
      S_MSE_GO: begin
        div_start = 1'b1;
        state_d   = S_MSE_WAIT;
      end
      S_MSE_WAIT: if (div_done) state_d = S_CPS_GO;
      S_CPS_GO: begin
        div_start = 1'b1;
        state_d   = S_CPS_WAIT;
      end
      S_CPS_WAIT: if (div_done) state_d = S_OUT;
      S_OUT:      state_d = S_LOAD;
      default:    state_d = S_LOAD;
    endcase
  end

  assign busy   = state_q != S_LOAD;
  assign done_o = state_q == S_OUT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      fpw_q   <= WEIGHT_W'(50);
      fnw_q   <= WEIGHT_W'(1);
      cnt_q   <= '0;
      faces_q <= '0;
      occ_q   <= '0;
      idx_q   <= '0;
      sum_q   <= '0;
      sqv_q   <= 1'b0;
      p1_q    <= 1'b0;
      p2_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i && cfg_idx_i == CFG_FP_WEIGHT) fpw_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == CFG_FN_WEIGHT) fnw_q <= cfg_data_i;
      sqv_q <= store;
      if (sqv_q) begin
        if (sat_q || sq >= SQ_MAX - sum_q) sum_q <= SQ_MAX;
        else sum_q <= sum_q + sq;
      end
      if (store) begin
        cnt_q <= cnt_q + 1'b1;
        occ_q <= occ_q + 1'b1;
        if (face_in) faces_q <= faces_q + 1'b1;
      end
      if (state_q == S_INIT) idx_q <= '0;
      if (pop) begin
        idx_q <= idx_q + 1'b1;
        occ_q <= occ_q - 1'b1;
      end
      p1_q <= pop;
      p2_q <= p1_q;
      if (state_q == S_OUT) begin
        cnt_q   <= '0;
        faces_q <= '0;
        sum_q   <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      sat_q <= ad_ext > 33'h1FFFFF;
      ad_q  <= ad_ext[20:0];
    end
    if (state_q == S_INIT) begin
      fp_q   <= cnt_q - faces_q;
      fn_q   <= '0;
      prev_q <= '0;
    end
    if (state_q == S_BEST) begin
      best_q <= COSTW'(fpw_q * fp_q);
      bfp_q  <= fp_q;
      bfn_q  <= '0;
      thr_q  <= '0;
    end
    if (pop) begin
      if (cell_data[0][SW]) begin
        fn_q  <= fn_q + 1'b1;
        fn1_q <= fn_q + 1'b1;
        fp1_q <= fp_q;
      end else begin
        fp_q  <= fp_q - 1'b1;
        fp1_q <= fp_q - 1'b1;
        fn1_q <= fn_q;
      end
      s1_q   <= $signed(cell_data[0][SW-1:0]);
      pr1_q  <= prev_q;
      prev_q <= $signed(cell_data[0][SW-1:0]);
    end
    m1_q  <= (COSTW-1)'(fpw_q * fp1_q);
    m2_q  <= (COSTW-1)'(fnw_q * fn1_q);
    fp2_q <= fp1_q;
    fn2_q <= fn1_q;
    s2_q  <= s1_q;
    pr2_q <= pr1_q;
    if (p2_q && cost < best_q) begin
      best_q <= cost;
      bfp_q  <= fp2_q;
      bfn_q  <= fn2_q;
      thr_q  <= $signed(mid[SW-1:0]);
    end
    if (state_q == S_MSE_WAIT && div_done) begin
      mse_q <= (mse_raw > (DW-14)'({MSE_W{1'b1}})) ? '1 : quot[14 +: MSE_W];
    end
    if (state_q == S_CPS_WAIT && div_done) begin
      cps_q <= (quot > DW'({CPS_W{1'b1}})) ? '1 : quot[CPS_W-1:0];
    end
  end

  assign best_threshold_o  = thr_q;
  assign false_pos_count_o = bfp_q;
  assign false_neg_count_o = bfn_q;
  assign best_cost_o       = (best_q > COSTW'({COST_OUT_W{1'b1}})) ? '1
                                                                   : best_q[COST_OUT_W-1:0];
  assign mean_sq_error_o   = mse_q;
  assign cost_per_sample_o = cps_q;
  assign face_count_o      = faces_q;
  assign sample_count_o    = cnt_q;
endmodule
`default_nettype wire

// ----- design/wts_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
module wts_cell import wts_pkg::*; #(
  parameter int SW  = WTS_SCORE_BITS,
  parameter int CW  = 11,
  parameter int IDX = 0
) (
  input  wire logic          clk_i,
  input  wire cell_ctrl_t    ctrl_i,
  input  wire logic [CW-1:0] occ_i,
  input  wire logic [SW:0]   key_i,
  input  wire logic [SW:0]   left_data_i,
  input  wire logic          left_keep_i,
  input  wire logic [SW:0]   right_data_i,
  output logic [SW:0]        data_o,
  output logic               keep_o
);
  logic [SW:0] data_q, data_d;
  logic        occupied;

  // Bit SW is the face flag, the rest is the score.
  assign occupied = 32'(IDX) < 32'(occ_i);
  assign keep_o = occupied &&
                  ($signed(data_q[SW-1:0]) <= $signed(key_i[SW-1:0]));
  assign data_o = data_q;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.insert && !keep_o) begin
      data_d = left_keep_i ? key_i : left_data_i;
    end else if (ctrl_i.shift) begin
      data_d = right_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end
endmodule
`default_nettype wire

// ----- design/wts_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module wts_div import wts_pkg::*; #(
  parameter int DW = SQ_W,
  parameter int VW = 11
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [VW-1:0] divisor_i,
  output logic               done_o,
  output logic [DW-1:0]      quot_o
);
  localparam int NW = $clog2(DW + 1);
  logic [DW-1:0] work_q, work_d;
  logic [VW-1:0] rem_q, rem_d, dvs_q;
  logic [NW-1:0] cnt_q, cnt_d;
  logic          run_q, run_d, done_q, done_d;
  logic [VW:0]   trial;

  assign trial  = {rem_q, work_q[DW-1]};
  assign quot_o = work_q;
  assign done_o = done_q;

  always_comb begin
    work_d = work_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      work_d = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      run_d  = 1'b1;
    end else if (run_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d  = VW'(trial - {1'b0, dvs_q});
        work_d = {work_q[DW-2:0], 1'b1};
      end else begin
        rem_d  = trial[VW-1:0];
        work_d = {work_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == NW'(DW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    if (start_i) dvs_q <= divisor_i;
  end
endmodule
`default_nettype wire

// ----- design/wts_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module wts_checker #(
  parameter int CW = 11
) (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          last_i,
  input wire logic          done_o,
  input wire logic [CW-1:0] false_pos_count_o,
  input wire logic [CW-1:0] face_count_o,
  input wire logic [CW-1:0] sample_count_o
);
  `WTS_ASSERT(a_last_sets_busy, start && !busy && last_i |=> busy)
  `WTS_ASSERT(a_done_only_busy, done_o |-> busy)
  `WTS_ASSERT(a_done_single, done_o |=> !done_o && !busy)
  `WTS_ASSERT(a_counts_fit, done_o |-> face_count_o <= sample_count_o &&
                            false_pos_count_o <= sample_count_o)
  `WTS_ASSERT_ALWAYS(a_reset_idle, !rst_ni ##1 !rst_ni |-> !busy && !done_o)
endmodule

bind weighted_threshold_selector_top wts_checker #(.CW(CW)) u_wts_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .last_i           (last_i),
  .done_o           (done_o),
  .false_pos_count_o(false_pos_count_o),
  .face_count_o     (face_count_o),
  .sample_count_o   (sample_count_o)
);
`default_nettype wire

// ----- tb/weighted_threshold_selector_top_tb.sv -----
`timescale 1ns / 1ps
module weighted_threshold_selector_top_tb;
  import wts_pkg::*;

  localparam int NSAMP = WTS_MAX_SAMPLES;
  // The longest quiet stretch is the evaluation of a full set.
  localparam int STALL_LIMIT = 20000;
  localparam int TAIL_CYCLES = 300;

  // One evaluated set as it appears on the result ports.
  typedef struct packed {
    logic [15:0] thr;
    logic [10:0] fp;
    logic [10:0] fn;
    logic [26:0] cost;
    logic [17:0] mse;
    logic [24:0] cps;
    logic [10:0] faces;
    logic [10:0] n;
  } set_result_t;

  // Tracks the loaded set, evaluates it when it closes and compares with what comes back.
  class wts_scoreboard;
    int unsigned fp_w = 50;
    int unsigned fn_w = 1;
    int          score_mem[NSAMP];
    bit          face_mem[NSAMP];
    int          sorted_score[NSAMP];
    bit          sorted_face[NSAMP];
    int unsigned loaded;
    int unsigned faces;
    longint unsigned sq_sum;
    set_result_t pending_q[$];
    int          errors;

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [WEIGHT_W-1:0] v);
      if (idx == CFG_FP_WEIGHT) fp_w = v;
      else if (idx == CFG_FN_WEIGHT) fn_w = v;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    // Stable insertion sort and the threshold sweep over the closed set.
    function set_result_t evaluate();
      set_result_t r;
      longint unsigned fp, fn, best, best_fp, best_fn, c, dv, mse, cps;
      longint      thr, prev, key;
      bit          kf;
      int          j;
      for (int i = 0; i < loaded; i++) begin
        key = score_mem[i];
        kf = face_mem[i];
        j = i;
        while (j > 0 && sorted_score[j-1] > key) begin
          sorted_score[j] = sorted_score[j-1];
          sorted_face[j] = sorted_face[j-1];
          j--;
        end
        sorted_score[j] = key;
        sorted_face[j] = kf;
      end
      fp = loaded - faces;
      fn = 0;
      best = fp_w * fp;
      best_fp = fp;
      best_fn = fn;
      thr = 0;
      prev = 0;
      for (int i = 0; i < loaded; i++) begin
        if (sorted_face[i]) fn++;
        else fp--;
        c = fp_w * fp + fn_w * fn;
        // Only a strictly lower cost moves the choice, so the earliest minimum stays.
        if (c < best) begin
          best = c;
          thr = (longint'(sorted_score[i]) + prev) >>> 1;
          best_fp = fp;
          best_fn = fn;
        end
        prev = sorted_score[i];
      end
      dv = (loaded == 0) ? 1 : loaded;
      mse = (sq_sum / dv) >> 14;
      if (mse > 64'h3FFFF) mse = 64'h3FFFF;
      cps = (best << 8) / dv;
      if (cps > 64'h1FFFFFF) cps = 64'h1FFFFFF;
      r.thr = thr[15:0];
      r.fp = best_fp[10:0];
      r.fn = best_fn[10:0];
      r.cost = (best > 64'h7FFFFFF) ? 27'h7FFFFFF : best[26:0];
      r.mse = mse[17:0];
      r.cps = cps[24:0];
      r.faces = faces[10:0];
      r.n = loaded[10:0];
      return r;
    endfunction

    function void note_beat(logic [15:0] s, logic [15:0] t, logic l);
      longint d;
      longint unsigned sq;
      longint unsigned sq_max;
      sq_max = (64'd1 << SQ_W) - 1;
      // Beats past a full store are dropped, but a dropped last still closes the set.
      if (loaded < NSAMP) begin
        d = longint'($signed(s)) - longint'($signed(t));
        if (d < 0) d = -d;
        sq = d * d;
        sq_sum = (sq >= sq_max - sq_sum) ? sq_max : sq_sum + sq;
        score_mem[loaded] = $signed(s);
        face_mem[loaded] = ($signed(t) == FACE_VALUE);
        if ($signed(t) == FACE_VALUE) faces++;
        loaded++;
      end
      if (l) begin
        pending_q.push_back(evaluate());
        loaded = 0;
        faces = 0;
        sq_sum = 0;
      end
    endfunction

    task check(set_result_t got);
      set_result_t w;
      if (pending_q.size() == 0) begin
        report("result with no set waiting");
      end else begin
        w = pending_q.pop_front();
        if (got.thr !== w.thr) report($sformatf("threshold %0d, want %0d",
                                                $signed(got.thr), $signed(w.thr)));
        if (got.fp !== w.fp) report($sformatf("fp %0d, want %0d", got.fp, w.fp));
        if (got.fn !== w.fn) report($sformatf("fn %0d, want %0d", got.fn, w.fn));
        if (got.cost !== w.cost) report($sformatf("cost %0d, want %0d", got.cost, w.cost));
        if (got.mse !== w.mse) report($sformatf("mse %0d, want %0d", got.mse, w.mse));
        if (got.cps !== w.cps) report($sformatf("cps %0d, want %0d", got.cps, w.cps));
        if (got.faces !== w.faces) report($sformatf("faces %0d, want %0d", got.faces, w.faces));
        if (got.n !== w.n) report($sformatf("samples %0d, want %0d", got.n, w.n));
      end
    endtask
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [15:0]          score_i = '0;
  logic [15:0]          target_i = '0;
  logic                 last_i = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [WEIGHT_W-1:0]  cfg_data_i = '0;
  logic                 done_o;
  logic [15:0]          best_threshold_o;
  logic [10:0]          false_pos_count_o, false_neg_count_o, face_count_o, sample_count_o;
  logic [26:0]          best_cost_o;
  logic [17:0]          mean_sq_error_o;
  logic [24:0]          cost_per_sample_o;

  wts_scoreboard sb = new();
  int            quiet_cycles = 0;

  weighted_threshold_selector_top i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .score_i(score_i), .target_i(target_i), .last_i(last_i),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .done_o(done_o), .best_threshold_o(best_threshold_o),
    .false_pos_count_o(false_pos_count_o), .false_neg_count_o(false_neg_count_o),
    .best_cost_o(best_cost_o), .mean_sq_error_o(mean_sq_error_o),
    .cost_per_sample_o(cost_per_sample_o), .face_count_o(face_count_o),
    .sample_count_o(sample_count_o)
  );

  always #5 clk_i = ~clk_i;

  // Results last a single cycle and cannot be held off, so every done cycle is captured.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      sb.check({best_threshold_o, false_pos_count_o, false_neg_count_o, best_cost_o,
                mean_sq_error_o, cost_per_sample_o, face_count_o, sample_count_o});
    end
  end

  // The watchdog restarts whenever a beat goes in or a result comes out.
  always @(posedge clk_i) begin
    if (rst_ni && ((start && !busy) || done_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("weighted_threshold_selector_top_tb: done, errors");
        $finish;
      end
    end
  end

  // Offers one beat after a random gap and holds it until the block takes it. The task
  // returns at a falling edge with start low, so a gapless next beat raises it again at
  // once without a visible drop.
  task automatic send_beat(logic [15:0] s, logic [15:0] t, logic l);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
    if ($urandom_range(0, 9) < 3) gap = 0;
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    score_i = s;
    target_i = t;
    last_i = l;
    start = 1'b1;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    sb.note_beat(s, t, l);
    @(negedge clk_i);
    start = 1'b0;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WEIGHT_W-1:0] v);
    cfg_idx_i = idx;
    cfg_data_i = v;
    cfg_we_i = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_reg(idx, v);
  endtask

  // Waits for every outstanding result, plus a margin, before the registers change.
  task automatic settle();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'd1;
      3: return WEIGHT_W'($urandom_range(0, 100));
      default: return WEIGHT_W'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_score();
    case ($urandom_range(0, 9))
      0, 1, 2: return 16'($signed($urandom_range(0, 8)) - 4) <<< 12;
      3: return 16'h8000;
      4: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_target();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 16'(FACE_VALUE);
      5: return 16'(FACE_VALUE - 1);
      6: return 16'(FACE_VALUE + 1);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_set(int size);
    for (int k = 1; k <= size; k++) send_beat(pick_score(), pick_target(), k == size);
  endtask

  initial begin
    int sent;
    int size;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: a lone face and a lone non-face under the reset weights.
    send_beat(16'd16384, 16'd16384, 1'b1);
    send_beat(16'hC000, 16'd0, 1'b1);
    // Field extremes, ties between faces and non-faces, and targets just off a face.
    send_beat(16'h8000, 16'h7FFF, 1'b0);
    send_beat(16'h7FFF, 16'h8000, 1'b0);
    send_beat(16'd100, 16'd16384, 1'b0);
    send_beat(16'd100, 16'd0, 1'b0);
    send_beat(16'd100, 16'd16384, 1'b0);
    send_beat(16'd100, 16'd16383, 1'b0);
    send_beat(16'hFFFF, 16'd16385, 1'b0);
    send_beat(16'h0000, 16'hFFFF, 1'b1);
    settle();
    // Weight extremes; out-of-range indexes must leave the weights alone.
    write_reg(CFG_FP_WEIGHT, 16'hFFFF);
    write_reg(CFG_FN_WEIGHT, 16'd0);
    write_reg(CFG_FN_WEIGHT + 1, 16'd7);
    write_reg(CFG_FN_WEIGHT + 2, 16'd9);
    send_beat(16'h8000, 16'd0, 1'b0);
    send_beat(16'h7FFF, 16'd16384, 1'b0);
    send_beat(16'd5, 16'd0, 1'b1);
    settle();
    write_reg(CFG_FP_WEIGHT, 16'd0);
    write_reg(CFG_FN_WEIGHT, 16'hFFFF);
    send_beat(16'd7, 16'd0, 1'b0);
    send_beat(16'd3, 16'd16384, 1'b0);
    send_beat(16'h8000, 16'd16384, 1'b1);
    settle();

    // A set that overfills the store; the trailing beats, last among them, are dropped.
    write_reg(CFG_FP_WEIGHT, 16'hFFFF);
    write_reg(CFG_FN_WEIGHT, 16'hFFFF);
    for (int k = 1; k <= NSAMP + 6; k++) send_beat(pick_score(), pick_target(), k == NSAMP + 6);
    settle();

    // Random sets, mostly small, with new weights every few sets.
    sent = 0;
    while (sent < 200) begin
      if ($urandom_range(0, 3) == 0) begin
        settle();
        write_reg(CFG_FP_WEIGHT, pick_weight());
        write_reg(CFG_FN_WEIGHT, pick_weight());
        if ($urandom_range(0, 4) == 0) write_reg(2'($urandom_range(2, 3)), WEIGHT_W'($urandom));
      end
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
      random_set(size);
      sent += size;
    end

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("weighted_threshold_selector_top_tb: done, clean");
    end else begin
      $display("weighted_threshold_selector_top_tb: done, errors");
    end
    $finish;
  end
endmodule
